@@ design/gwm_pkg.sv @@
package gwm_pkg;

    // item commands
    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_NAME   = 2'd2,
        CMD_END    = 2'd3
    } gwm_cmd_t;

    // wildcard characters
    localparam logic [7:0] STAR_CHAR = 8'h2A;
    localparam logic [7:0] ANY_CHAR  = 8'h3F;

    // controls broadcast to every cell
    typedef struct packed {
        logic       step;
        logic       restart;
        logic [7:0] char_code;
    } gwm_bcast_t;

    // signals handed from one cell to its right neighbor
    typedef struct packed {
        logic fwd;
        logic close;
    } gwm_link_t;

endpackage

@@ design/gwm_if.sv @@
interface gwm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] char_code;

    modport source (output valid, output command, output char_code, input ready);
    modport sink   (input valid, input command, input char_code, output ready);
endinterface

interface gwm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source (output valid, output matched, output pattern_overflow, input ready);
    modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

@@ design/gwm_cell.sv @@
module gwm_cell #(
    parameter int INDEX = 0,
    parameter int LEN_W = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gwm_pkg::gwm_bcast_t bcast,
    input  logic                wr_en,
    input  logic [LEN_W-1:0]    plen,
    input  gwm_pkg::gwm_link_t  left,
    output gwm_pkg::gwm_link_t  right,
    output logic                hit
);

    localparam logic [LEN_W-1:0] POS = LEN_W'(INDEX);
    localparam logic START_ACTIVE = (INDEX == 0);

    logic [7:0] char_reg;
    logic       active_reg;
    logic       active_next;
    logic       in_pattern;
    logic       is_star;
    logic       is_any;
    logic       cur;
    logic       nxt;

    // pattern character held by this position
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            char_reg <= bcast.char_code;
        end
    end

    // position decode
    assign in_pattern = (POS < plen);
    assign is_star    = in_pattern && (char_reg == gwm_pkg::STAR_CHAR);
    assign is_any     = (char_reg == gwm_pkg::ANY_CHAR);

    // active after star closure from the left neighbor
    assign cur = active_reg | left.close;

    // links to the right neighbor
    assign right.close = active_reg & is_star;
    assign right.fwd   = cur & in_pattern & ~is_star
                         & (is_any | (char_reg == bcast.char_code));

    // next active bit after one name character
    assign nxt = (cur & is_star) | left.fwd;

    // end position report
    assign hit = cur & (POS == plen);

    always_comb
    begin
        active_next = active_reg;
        if (bcast.restart)
        begin
            active_next = START_ACTIVE;
        end
        else if (bcast.step)
        begin
            active_next = nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= START_ACTIVE;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

endmodule

@@ design/glob_wildcard_matcher.sv @@
// Glob matcher: load a pattern one character per item (append / clear), then
// stream name characters and finish each name with an end item, which yields
// one result (matched, pattern_overflow) in the output register on the next
// cycle. One item is accepted per cycle; intake only pauses while an
// undelivered result blocks the output register. The rate rests on the
// row of MAX_PATTERN+1 position cells, each updating its active bit from its
// own character and its left neighbor in one step. Runs of consecutive '*'
// are stored as a single star (same language), so star closure never spans
// more than one neighbor. Characters past MAX_PATTERN are dropped and raise
// pattern_overflow until the next clear.
module glob_wildcard_matcher #(
    parameter int MAX_PATTERN = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    gwm_in_if.sink    req,
    gwm_out_if.source rsp
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

    logic [LEN_W-1:0] plen_reg;
    logic [LEN_W-1:0] plen_next;
    logic [LEN_W-1:0] llen_reg;
    logic [LEN_W-1:0] llen_next;
    logic             last_star_reg;
    logic             last_star_next;
    logic             overflow_reg;
    logic             overflow_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             matched_reg;
    logic             ovf_out_reg;

    logic                in_ready;
    logic                fire;
    gwm_pkg::gwm_cmd_t   cmd;
    logic                store_en;
    logic                end_fire;
    gwm_pkg::gwm_bcast_t bcast;
    gwm_pkg::gwm_link_t  links [0:MAX_PATTERN+1];
    logic [MAX_PATTERN:0] hits;

    // handshake
    assign in_ready  = ~out_valid_reg | rsp.ready;
    assign req.ready = in_ready;
    assign fire      = req.valid & in_ready;
    assign cmd       = gwm_pkg::gwm_cmd_t'(req.command);
    assign end_fire  = fire && (cmd == gwm_pkg::CMD_END);

    // broadcast to cells
    assign bcast.step      = fire && (cmd == gwm_pkg::CMD_NAME);
    assign bcast.restart   = fire && (cmd != gwm_pkg::CMD_NAME);
    assign bcast.char_code = req.char_code;

    // pattern length bookkeeping
    always_comb
    begin
        plen_next      = plen_reg;
        llen_next      = llen_reg;
        last_star_next = last_star_reg;
        overflow_next  = overflow_reg;
        store_en       = 1'b0;
        if (fire)
        begin
            case (cmd)
                gwm_pkg::CMD_APPEND:
                begin
                    if (llen_reg < MAX_LEN)
                    begin
                        llen_next = llen_reg + LEN_W'(1);
                        if (!(last_star_reg && (req.char_code == gwm_pkg::STAR_CHAR)))
                        begin
                            store_en       = 1'b1;
                            plen_next      = plen_reg + LEN_W'(1);
                            last_star_next = (req.char_code == gwm_pkg::STAR_CHAR);
                        end
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                end
                gwm_pkg::CMD_CLEAR:
                begin
                    plen_next      = '0;
                    llen_next      = '0;
                    last_star_next = 1'b0;
                    overflow_next  = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg      <= '0;
            llen_reg      <= '0;
            last_star_reg <= 1'b0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            plen_reg      <= plen_next;
            llen_reg      <= llen_next;
            last_star_reg <= last_star_next;
            overflow_reg  <= overflow_next;
        end
    end

    // row of position cells
    assign links[0] = '0;

    for (genvar i = 0; i <= MAX_PATTERN; i++)
    begin : g_cell
        gwm_cell #(
            .INDEX (i),
            .LEN_W (LEN_W)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .bcast (bcast),
            .wr_en (store_en && (plen_reg == LEN_W'(i))),
            .plen  (plen_reg),
            .left  (links[i]),
            .right (links[i+1]),
            .hit   (hits[i])
        );
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (end_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (end_fire)
        begin
            matched_reg <= |hits;
            ovf_out_reg <= overflow_reg;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.matched          = matched_reg;
    assign rsp.pattern_overflow = ovf_out_reg;

    // checks
    a_plen_le_llen: assert property (@(posedge clk) disable iff (!rst_n)
        plen_reg <= llen_reg)
        else $error("stored length exceeds logical length");

    a_llen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        llen_reg <= MAX_LEN)
        else $error("pattern length beyond store");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> (llen_reg == MAX_LEN))
        else $error("overflow set with room in pattern");

    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        end_fire |=> rsp.valid)
        else $error("end item gave no result");

endmodule

@@ tb/glob_wildcard_matcher_checker.sv @@
`timescale 1ns / 100ps

module glob_wildcard_matcher_checker #(
    parameter int MAX_PATTERN = 64
) (
    input  logic clk,
    input  logic rst_n,
    gwm_in_if    req,
    gwm_out_if   rsp,
    output int   mismatches,
    output int   pending
);

    localparam logic [MAX_PATTERN:0] FIRST_ONLY = {{MAX_PATTERN{1'b0}}, 1'b1};

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } verdict_t;

    // predicted verdicts, oldest first
    verdict_t verdict_q[$];

    // own copy of the pattern and the live position set
    logic [7:0]           pat_mem [MAX_PATTERN];
    int unsigned          pat_len;
    logic [MAX_PATTERN:0] live;
    logic                 dropped;
    logic [MAX_PATTERN:0] final_set;
    verdict_t             want;
    verdict_t             got;

    // a star at i also makes i+1 live, cascading to the right
    function automatic logic [MAX_PATTERN:0] spread_stars(input logic [MAX_PATTERN:0] s);
        for (int i = 0; i < pat_len; i++)
        begin
            if (s[i] && pat_mem[i] == gwm_pkg::STAR_CHAR)
                s[i + 1] = 1'b1;
        end
        return s;
    endfunction

    // live set after consuming one name character
    function automatic logic [MAX_PATTERN:0] consume_char(input logic [7:0] ch);
        logic [MAX_PATTERN:0] cur;
        logic [MAX_PATTERN:0] nxt;
        cur = spread_stars(live);
        nxt = '0;
        for (int i = 0; i < pat_len; i++)
        begin
            if (cur[i])
            begin
                if (pat_mem[i] == gwm_pkg::STAR_CHAR)
                    nxt[i] = 1'b1;
                else if (pat_mem[i] == gwm_pkg::ANY_CHAR || pat_mem[i] == ch)
                    nxt[i + 1] = 1'b1;
            end
        end
        return nxt;
    endfunction

    task automatic report_mismatch(input string what, input logic seen, input logic wanted);
        $display("[%0t] mismatch on %s: got %b, expected %b", $time, what, seen, wanted);
        mismatches++;
    endtask

    // track accepted items, then check delivered results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len    = 0;
            dropped    = 1'b0;
            live       = FIRST_ONLY;
            verdict_q.delete();
            pending    = 0;
            mismatches = 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                case (req.command)
                    gwm_pkg::CMD_APPEND:
                    begin
                        if (pat_len < MAX_PATTERN)
                        begin
                            pat_mem[pat_len] = req.char_code;
                            pat_len++;
                        end
                        else
                            dropped = 1'b1;
                        live = FIRST_ONLY;
                    end
                    gwm_pkg::CMD_CLEAR:
                    begin
                        pat_len = 0;
                        dropped = 1'b0;
                        live    = FIRST_ONLY;
                    end
                    gwm_pkg::CMD_NAME:
                        live = consume_char(req.char_code);
                    default:
                    begin
                        final_set = spread_stars(live);
                        want.matched          = final_set[pat_len];
                        want.pattern_overflow = dropped;
                        verdict_q.push_back(want);
                        live = FIRST_ONLY;
                    end
                endcase
            end

            if (rsp.valid && rsp.ready)
            begin
                got.matched          = rsp.matched;
                got.pattern_overflow = rsp.pattern_overflow;
                if (verdict_q.size() == 0)
                    report_mismatch("unexpected result", got.matched, 1'bx);
                else
                begin
                    want = verdict_q.pop_front();
                    if (got.matched !== want.matched)
                        report_mismatch("matched", got.matched, want.matched);
                    if (got.pattern_overflow !== want.pattern_overflow)
                        report_mismatch("pattern_overflow", got.pattern_overflow,
                                        want.pattern_overflow);
                end
            end
            pending = verdict_q.size();
        end
    end

endmodule

@@ tb/glob_wildcard_matcher_test.sv @@
`timescale 1ns / 100ps

module glob_wildcard_matcher_test;

    localparam int MAX_PATTERN  = 64;
    localparam int ITEM_TARGET  = 500;
    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE_TICKS = 8;

    logic clk;
    logic rst_n;

    gwm_in_if  req();
    gwm_out_if rsp();

    int mismatches;
    int pending;
    int items_sent  = 0;
    int idle_cycles = 0;
    int burst_left  = 0;
    int phase_left  = 0;
    int stall_mode  = 0;
    int round_no    = 0;
    int directed_n  = 0;
    int pick;
    int pat_len_req;
    bit hold_ask    = 1'b0;
    bit hold_taken  = 1'b0;

    // pattern as appended, before the block merges star runs, used only to build names
    logic [7:0] pat_copy[$];

    glob_wildcard_matcher #(.MAX_PATTERN(MAX_PATTERN)) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    glob_wildcard_matcher_checker #(.MAX_PATTERN(MAX_PATTERN)) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // result side backpressure, with one long hold on request
    initial
    begin
        rsp.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_ask && !hold_taken)
            begin
                hold_taken = 1'b1;
                rsp.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else
            begin
                if (phase_left == 0)
                begin
                    stall_mode = $urandom_range(0, 2);
                    phase_left = $urandom_range(10, 60);
                end
                phase_left--;
                case (stall_mode)
                    0:       rsp.ready <= 1'b1;
                    1:       rsp.ready <= 1'($urandom_range(0, 1));
                    default: rsp.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // offer one item in bursts with random gaps, return at the falling edge after acceptance
    task automatic send_item(input gwm_pkg::gwm_cmd_t cmd, input logic [7:0] ch);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        req.valid     <= 1'b1;
        req.command   <= cmd;
        req.char_code <= ch;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
        if (cmd == gwm_pkg::CMD_APPEND && pat_copy.size() < MAX_PATTERN)
            pat_copy.push_back(ch);
        else if (cmd == gwm_pkg::CMD_CLEAR)
            pat_copy.delete();
    endtask

    // stop offering until every end item has its result
    task automatic drain_results();
        req.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    function automatic logic [7:0] pattern_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return gwm_pkg::STAR_CHAR;
        else if (r == 2)
            return gwm_pkg::ANY_CHAR;
        else if (r < 6)
            return "a";
        else if (r == 6)
            return "b";
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] name_char();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0)
            return "a";
        else if (r == 1)
            return "b";
        return 8'($urandom_range(0, 255));
    endfunction

    // name built to fit the current pattern, with an occasional wrong or dropped char
    task automatic send_fitting_name();
        logic [7:0] chars[$];
        int         k;
        foreach (pat_copy[i])
        begin
            if (pat_copy[i] == gwm_pkg::STAR_CHAR)
            begin
                k = $urandom_range(0, 3);
                repeat (k) chars.push_back(name_char());
            end
            else if (pat_copy[i] == gwm_pkg::ANY_CHAR)
                chars.push_back(name_char());
            else
                chars.push_back(pat_copy[i]);
        end
        foreach (chars[i])
        begin
            if ($urandom_range(0, 15) == 0)
                chars[i] = name_char();
        end
        if ($urandom_range(0, 9) == 0 && chars.size() > 0)
            void'(chars.pop_back());
        foreach (chars[i])
            send_item(gwm_pkg::CMD_NAME, chars[i]);
        send_item(gwm_pkg::CMD_END, 8'($urandom_range(0, 255)));
    endtask

    // stimulus
    initial
    begin
        rst_n         <= 1'b0;
        req.valid     <= 1'b0;
        req.command   <= gwm_pkg::CMD_CLEAR;
        req.char_code <= 8'h00;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty pattern: only the empty name fits
        send_item(gwm_pkg::CMD_END, 8'h00);
        send_item(gwm_pkg::CMD_NAME, 8'h00);
        send_item(gwm_pkg::CMD_END, 8'h00);
        // extreme bytes with both wildcards
        send_item(gwm_pkg::CMD_APPEND, 8'hFF);
        send_item(gwm_pkg::CMD_APPEND, gwm_pkg::STAR_CHAR);
        send_item(gwm_pkg::CMD_APPEND, gwm_pkg::ANY_CHAR);
        send_item(gwm_pkg::CMD_NAME, 8'hFF);
        send_item(gwm_pkg::CMD_NAME, 8'h00);
        send_item(gwm_pkg::CMD_NAME, "x");
        send_item(gwm_pkg::CMD_END, 8'hFF);
        send_item(gwm_pkg::CMD_NAME, 8'hFF);
        send_item(gwm_pkg::CMD_END, 8'h00);
        // pattern grows in the middle of a name, which restarts it
        send_item(gwm_pkg::CMD_NAME, 8'hFF);
        send_item(gwm_pkg::CMD_APPEND, "A");
        send_item(gwm_pkg::CMD_NAME, 8'hFF);
        send_item(gwm_pkg::CMD_NAME, "b");
        send_item(gwm_pkg::CMD_NAME, "A");
        send_item(gwm_pkg::CMD_END, 8'h00);
        // clear ignores its byte
        send_item(gwm_pkg::CMD_CLEAR, 8'hFF);
        send_item(gwm_pkg::CMD_END, 8'h00);
        // lone star, zero byte as a normal char
        send_item(gwm_pkg::CMD_APPEND, gwm_pkg::STAR_CHAR);
        send_item(gwm_pkg::CMD_END, 8'h00);
        send_item(gwm_pkg::CMD_NAME, 8'h00);
        send_item(gwm_pkg::CMD_END, 8'h00);
        send_item(gwm_pkg::CMD_END, 8'hFF);
        directed_n = items_sent;

        // random rounds: mostly pattern loads followed by fitting names
        while (items_sent < directed_n + ITEM_TARGET)
        begin
            round_no++;
            if (round_no == 4)
                hold_ask = 1'b1;
            if (round_no % 10 == 3)
                drain_results();
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                if ($urandom_range(0, 1))
                    send_item(gwm_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 14) == 0)
                    pat_len_req = $urandom_range(MAX_PATTERN - 2, MAX_PATTERN + 6);
                else
                    pat_len_req = $urandom_range(0, 6);
                repeat (pat_len_req) send_item(gwm_pkg::CMD_APPEND, pattern_char());
                repeat ($urandom_range(1, 4)) send_fitting_name();
            end
            else if (pick < 9)
            begin
                repeat ($urandom_range(1, 8))
                    send_item(gwm_pkg::gwm_cmd_t'($urandom_range(0, 3)),
                              8'($urandom_range(0, 255)));
            end
            else
            begin
                // broken name: pattern changes after a few chars
                repeat ($urandom_range(1, 3)) send_item(gwm_pkg::CMD_NAME, name_char());
                if ($urandom_range(0, 1))
                    send_item(gwm_pkg::CMD_APPEND, pattern_char());
                else
                    send_item(gwm_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
                send_fitting_name();
            end
        end

        // let every result arrive, then idle before the report
        req.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
